// ----- hw/rtl/rmi_pkg.sv -----
`default_nettype none

package rmi_pkg;

   // Table geometry.
   localparam int ENTRIES = 64;
   localparam int TABLES  = 2;

   // Field widths of the channels.
   localparam int SEL_W    = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int NOW_W    = 7;

   // Derived widths.
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int OUT_W  = $clog2(ENTRIES + 3);
   localparam int TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int ROWS   = TABLES * 2 * ENTRIES;
   localparam int ADDR_W = $clog2(ROWS);

   // End of the address space, one past the last byte.
   localparam logic [WORD_W:0] SPAN = {1'b1, {WORD_W{1'b0}}};

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_TABLE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] start;
      logic [WORD_W-1:0] load;
      logic [WORD_W-1:0] size;
      logic [WORD_W-1:0] attr;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic setup;
      logic rd;
      logic load;
      logic ev;
      logic tail;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bad;
      logic zero;
      logic empty;
      logic entry_done;
      logic last_entry;
   } sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rmi_if.sv -----
`default_nettype none

interface rmi_req_if;
   logic                            valid;
   logic                            ready;
   logic [rmi_pkg::SEL_W-1:0]       table_select;
   logic [rmi_pkg::WORD_W-1:0]      virt_base;
   logic [rmi_pkg::WORD_W-1:0]      load_base;
   logic [rmi_pkg::WORD_W-1:0]      range_length;

   modport source (output valid, output table_select, output virt_base,
                   output load_base, output range_length, input ready);
   modport sink (input valid, input table_select, input virt_base,
                 input load_base, input range_length, output ready);
endinterface

interface rmi_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rmi_pkg::STATUS_W-1:0]    status;
   logic [rmi_pkg::NOW_W-1:0]       entries_now;

   modport source (output valid, output status, output entries_now, input ready);
   modport sink (input valid, input status, input entries_now, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rmi_ctrl.sv -----
`default_nettype none

module rmi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmi_pkg::cmd_type cmd,
   input  rmi_pkg::sts_type sts
);
   import rmi_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_LD    = 3'd3;
   localparam logic [2:0] S_EV    = 3'd4;
   localparam logic [2:0] S_TAIL  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            if (sts.bad || sts.zero) begin
               state_in = S_DONE;
            end else if (sts.empty) begin
               state_in = S_TAIL;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_LD;
         end
         S_LD: begin
            cmd.load = 1'b1;
            state_in = S_EV;
         end
         S_EV: begin
            cmd.ev = 1'b1;
            if (sts.entry_done) begin
               state_in = sts.last_entry ? S_TAIL : S_RD;
            end
         end
         S_TAIL: begin
            cmd.tail = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rmi_datapath.sv -----
`default_nettype none

module rmi_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  rmi_pkg::cmd_type               cmd,
   output rmi_pkg::sts_type               sts,
   input  logic [rmi_pkg::SEL_W-1:0]      req_table_select,
   input  logic [rmi_pkg::WORD_W-1:0]     req_virt_base,
   input  logic [rmi_pkg::WORD_W-1:0]     req_load_base,
   input  logic [rmi_pkg::WORD_W-1:0]     req_range_length,
   output logic [rmi_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rmi_pkg::NOW_W-1:0]      rsp_entries_now
);
   import rmi_pkg::*;

   // Both banks of every table live in one memory; a table's bank flag
   // names the bank holding its live entries, the other one is rebuilt.
   entry_type mem [ROWS];

   logic [SEL_W-1:0]   sel_ff;
   logic [WORD_W-1:0]  va_ff, la_ff, ln_ff;
   logic [WORD_W:0]    end_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [OUT_W-1:0]   out_ff;
   logic               found_ff;
   entry_type          rd_ff, cur_ff, cur_in;
   logic [WORD_W:0]    cur_e_ff;
   logic               bank_ff  [TABLES];
   logic [CNT_W-1:0]   count_ff [TABLES];
   logic [STATUS_W-1:0] status_ff;
   logic [NOW_W-1:0]   now_ff;

   logic [TBL_W-1:0]   tsel;
   logic               bank;
   logic [CNT_W-1:0]   n0;
   logic               bad, zero, full;
   logic [WORD_W:0]    sum;
   logic               clip;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   entry_type          new_ent, wr_data;
   logic               ev_wr, ev_done, ev_found, cur_upd;
   logic               wr_go;
   logic [WORD_W-1:0]  head, trim;

   function automatic logic [ADDR_W-1:0] row_addr(input logic [TBL_W-1:0] t,
                                                  input logic b,
                                                  input logic [IDX_W-1:0] i);
      return ADDR_W'(t) * ADDR_W'(2 * ENTRIES) + ADDR_W'(b) * ADDR_W'(ENTRIES)
             + ADDR_W'(i);
   endfunction

   assign tsel = sel_ff[TBL_W-1:0];
   assign bank = bank_ff[tsel];
   assign n0   = count_ff[tsel];
   assign bad  = ({1'b0, sel_ff} >= (SEL_W + 1)'(TABLES));
   assign zero = (ln_ff == '0);
   assign full = (out_ff > OUT_W'(ENTRIES));
   assign sum  = {1'b0, va_ff} + {1'b0, ln_ff};
   assign clip = (sum > SPAN);

   assign rd_addr = row_addr(tsel, bank, idx_ff);
   assign wr_addr = row_addr(tsel, !bank, out_ff[IDX_W-1:0]);

   assign new_ent = '{start: va_ff, load: la_ff, size: ln_ff, attr: '0};
   assign head    = va_ff - cur_ff.start;
   assign trim    = end_ff[WORD_W-1:0] - cur_ff.start;

   // One step on the held entry: at most one row is written per cycle.
   always_comb begin
      ev_wr    = 1'b0;
      ev_done  = 1'b1;
      ev_found = 1'b0;
      cur_upd  = 1'b0;
      wr_data  = cur_ff;
      cur_in   = cur_ff;
      if (!found_ff) begin
         if (cur_ff.start > va_ff) begin
            ev_wr    = 1'b1;
            wr_data  = new_ent;
            ev_found = 1'b1;
            ev_done  = 1'b0;
         end else if ({1'b0, va_ff} < cur_e_ff) begin
            if (cur_ff.start != va_ff) begin
               ev_wr        = 1'b1;
               wr_data.size = head;
               cur_upd      = 1'b1;
               cur_in.start = va_ff;
               cur_in.load  = cur_ff.load + head;
               cur_in.size  = cur_ff.size - head;
               ev_done      = 1'b0;
            end else if (cur_ff.size <= ln_ff) begin
               ev_wr        = 1'b1;
               wr_data.load = la_ff;
               wr_data.size = ln_ff;
               ev_found     = 1'b1;
            end else begin
               ev_wr        = 1'b1;
               wr_data      = new_ent;
               cur_upd      = 1'b1;
               cur_in.start = va_ff + ln_ff;
               cur_in.load  = cur_ff.load + ln_ff;
               cur_in.size  = cur_ff.size - ln_ff;
               ev_found     = 1'b1;
               ev_done      = 1'b0;
            end
         end else begin
            ev_wr = 1'b1;
         end
      end else begin
         if (cur_e_ff <= end_ff) begin
            ev_wr = 1'b0;
         end else if ({1'b0, cur_ff.start} < end_ff) begin
            ev_wr         = 1'b1;
            wr_data.start = end_ff[WORD_W-1:0];
            wr_data.load  = cur_ff.load + trim;
            wr_data.size  = cur_ff.size - trim;
         end else begin
            ev_wr = 1'b1;
         end
      end
      if (cmd.tail) begin
         wr_data = new_ent;
      end
   end

   assign wr_go = (cmd.ev && ev_wr) || (cmd.tail && !found_ff);

   assign sts.bad        = bad;
   assign sts.zero       = zero;
   assign sts.empty      = (n0 == '0);
   assign sts.entry_done = ev_done;
   assign sts.last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == n0);

   assign rsp_status      = status_ff;
   assign rsp_entries_now = now_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff <= mem[rd_addr];
      end
      if (wr_go && (out_ff < OUT_W'(ENTRIES))) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sel_ff <= req_table_select;
         va_ff  <= req_virt_base;
         la_ff  <= req_load_base;
         ln_ff  <= req_range_length;
      end else if (cmd.setup) begin
         ln_ff  <= clip ? (WORD_W'(0) - va_ff) : ln_ff;
         end_ff <= clip ? SPAN : sum;
      end
      if (cmd.load) begin
         cur_ff   <= rd_ff;
         cur_e_ff <= {1'b0, rd_ff.start} + {1'b0, rd_ff.size};
      end else if (cmd.ev && cur_upd) begin
         cur_ff <= cur_in;
      end
      if (cmd.finish) begin
         if (bad) begin
            status_ff <= ST_BAD_TABLE;
            now_ff    <= '0;
         end else if (zero) begin
            status_ff <= ST_OK;
            now_ff    <= NOW_W'(n0);
         end else if (full) begin
            status_ff <= ST_FULL;
            now_ff    <= NOW_W'(n0);
         end else begin
            status_ff <= ST_OK;
            now_ff    <= NOW_W'(out_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         out_ff   <= '0;
         found_ff <= 1'b0;
         for (int t = 0; t < TABLES; t++) begin
            bank_ff[t]  <= 1'b0;
            count_ff[t] <= '0;
         end
      end else begin
         if (cmd.capture) begin
            idx_ff   <= '0;
            out_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (wr_go) begin
               out_ff <= out_ff + OUT_W'(1);
            end
            if (cmd.ev && ev_found) begin
               found_ff <= 1'b1;
            end
            if (cmd.ev && ev_done && !sts.last_entry) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         if (cmd.finish && !bad && !zero && !full) begin
            bank_ff[tsel]  <= !bank;
            count_ff[tsel] <= CNT_W'(out_ff);
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/range_map_insert_with_overlap_trim_top.sv -----
// Flow: an invalid table or a zero length skips the table walk and goes straight to the response;
// otherwise every entry of the table is walked, and an entry takes extra evaluate steps where the
// new range is placed ahead of it or splits it.
// Throughput: one request at a time; each old entry is read, held, then evaluated.
// Reset: synchronous, active high; entry counts and bank flags clear, table memory is not
// cleared, so every table reads as empty after reset.
`default_nettype none

module range_map_insert_with_overlap_trim_top (
   input  logic      clock,
   input  logic      reset,
   rmi_req_if.sink   req_bus,
   rmi_rsp_if.source rsp_bus
);
   import rmi_pkg::*;

   // The controller sequences one insert: capture the request beat, clip the
   // length, then stream the table's live bank entry by entry through the
   // datapath. Each entry is read, held, and then rewritten into the spare
   // bank, trimmed, split or dropped as the new range dictates. When the
   // stream ends the new range is appended if it was not yet placed.
   cmd_type cmd;
   sts_type sts;

   rmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath owns the table memory. A rebuilt bank only becomes live when
   // the insert fits; an overfull result simply leaves the old bank in place,
   // so a dropped insert needs no undo.
   rmi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_table_select (req_bus.table_select),
      .req_virt_base    (req_bus.virt_base),
      .req_load_base    (req_bus.load_base),
      .req_range_length (req_bus.range_length),
      .rsp_status       (rsp_bus.status),
      .rsp_entries_now  (rsp_bus.entries_now)
   );

endmodule

`default_nettype wire
